[rtl/ebp_pkg.sv]
// package for the embedding-bag pooling block
// request, result and command types plus fixed codes; no dependencies
`default_nettype none

package ebp_pkg;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic POOL_SUM  = 1'b0;
   localparam logic POOL_MEAN = 1'b1;

   localparam logic CSR_POOLING_MODE = 1'b0;
   localparam logic CSR_EMB_DIM_USED = 1'b1;

   localparam logic [4:0] EMB_DIM_RESET = 5'd16;

   localparam logic signed [15:0] Q88_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Q88_MIN = 16'sh8000;

   typedef struct packed {
      logic               req_type;
      logic [9:0]         row_index;
      logic [3:0]         column;
      logic signed [15:0] weight_value;
      logic               last_in_bag;
   } request_type;

   typedef struct packed {
      logic signed [15:0] pooled_value;
      logic [3:0]         out_column;
      logic               last_of_bag;
   } result_type;

   typedef struct packed {
      logic wr_en;
      logic lookup_load;
      logic acc_issue;
      logic acc_read;
      logic emit_sum;
      logic div_start;
      logic emit_div;
      logic last_col;
      logic clear;
   } ebp_cmd_type;

endpackage

`default_nettype wire

[rtl/ebp_div.sv]
// iterative divider: signed 32-bit sum by unsigned 16-bit count, one bit a cycle
// gives quotient magnitude and sign, truncation toward zero; no dependencies
`default_nettype none

module ebp_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] dividend,
   input  wire logic [15:0]        divisor,
   output logic                    done,
   output logic [31:0]             quotient,
   output logic                    negative
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [16:0] shifted;
   logic [16:0] diff;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      ge      = shifted >= {1'b0, div_ff};
      diff    = shifted - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[31] ? 32'(-dividend) : 32'(dividend);
         div_in  = divisor;
         neg_in  = dividend[31];
      end else if (busy_ff) begin
         rem_in  = ge ? diff[15:0] : shifted[15:0];
         quo_in  = {quo_ff[30:0], ge};
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign negative = neg_ff;

endmodule

`default_nettype wire

[rtl/ebp_datapath.sv]
// datapath: weight table, column accumulators, bag count, divider, result register
// uses ebp_pkg types and ebp_div
`default_nettype none

module ebp_datapath #(
   parameter int ROWS    = 1024,
   parameter int MAX_DIM = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ebp_pkg::ebp_cmd_type cmd,
   input  wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] col,
   input  wire ebp_pkg::request_type req,
   output logic                     div_done,
   output logic                     rsp_strobe,
   output ebp_pkg::result_type      rsp_data
);

   localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH = ROWS * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   logic signed [15:0] wt_mem [DEPTH];
   logic signed [31:0] acc_mem [MAX_DIM];
   logic [MAX_DIM-1:0] acc_vld_ff;

   logic [AW-1:0]      wr_addr, rd_addr;
   logic               wr_ok;
   logic [9:0]         row_ff;
   logic               row_ok_ff;
   logic [15:0]        cnt_ff;
   logic signed [15:0] wt_rd_ff;
   logic signed [31:0] acc_rd_ff;
   logic               acc_rdv_ff;
   logic               s1_vld_ff;
   logic [CW-1:0]      s1_col_ff;
   logic signed [31:0] acc_cur;
   logic signed [15:0] wt_cur;
   logic [32:0]        sum33;
   logic signed [31:0] add_sat;
   logic signed [15:0] sum_q88;
   logic signed [15:0] div_q88;
   logic [31:0]        div_quo;
   logic               div_neg;
   logic               rsp_strobe_ff;
   ebp_pkg::result_type rsp_ff;

   assign wr_ok   = (32'(req.row_index) < ROWS) && (32'(req.column) < MAX_DIM);
   assign wr_addr = AW'(req.row_index) * AW'(MAX_DIM) + AW'(req.column);
   assign rd_addr = AW'(row_ff) * AW'(MAX_DIM) + AW'(col);

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         wt_mem[wr_addr] <= req.weight_value;
      end
      if (cmd.acc_issue) begin
         wt_rd_ff <= wt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         acc_mem[s1_col_ff] <= add_sat;
      end
      if (cmd.acc_issue || cmd.acc_read) begin
         acc_rd_ff <= acc_mem[col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         acc_vld_ff <= '0;
      end else if (s1_vld_ff) begin
         acc_vld_ff[s1_col_ff] <= 1'b1;
      end
      if (cmd.acc_issue || cmd.acc_read) begin
         acc_rdv_ff <= acc_vld_ff[col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         s1_vld_ff <= cmd.acc_issue;
         if (cmd.clear) begin
            cnt_ff <= '0;
         end else if (cmd.lookup_load && cnt_ff != 16'hFFFF) begin
            cnt_ff <= cnt_ff + 16'd1;
         end
      end
      s1_col_ff <= col;
      if (cmd.lookup_load) begin
         row_ff    <= req.row_index;
         row_ok_ff <= 32'(req.row_index) < ROWS;
      end
   end

   // saturating accumulate
   always_comb begin
      acc_cur = acc_rdv_ff ? acc_rd_ff : '0;
      wt_cur  = row_ok_ff ? wt_rd_ff : '0;
      sum33   = {acc_cur[31], acc_cur} + {{17{wt_cur[15]}}, wt_cur};
      if (sum33[32] != sum33[31]) begin
         add_sat = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         add_sat = sum33[31:0];
      end
   end

   // saturation to q8.8
   always_comb begin
      if (acc_cur > 32'sd32767) begin
         sum_q88 = ebp_pkg::Q88_MAX;
      end else if (acc_cur < -32'sd32768) begin
         sum_q88 = ebp_pkg::Q88_MIN;
      end else begin
         sum_q88 = acc_cur[15:0];
      end
      if (div_neg) begin
         div_q88 = (div_quo > 32'd32768) ? ebp_pkg::Q88_MIN : 16'(32'd0 - div_quo);
      end else begin
         div_q88 = (div_quo > 32'd32767) ? ebp_pkg::Q88_MAX : div_quo[15:0];
      end
   end

   ebp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_cur),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quo),
      .negative (div_neg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit_sum || cmd.emit_div;
      end
      if (cmd.emit_sum || cmd.emit_div) begin
         rsp_ff.pooled_value <= cmd.emit_sum ? sum_q88 : div_q88;
         rsp_ff.out_column   <= 4'(col);
         rsp_ff.last_of_bag  <= cmd.last_col;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

[rtl/ebp_ctrl.sv]
// controller: sequences writes, per-column accumulation and the bag's results
// uses ebp_pkg command type and codes
`default_nettype none

module ebp_ctrl #(
   parameter int MAX_DIM = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                req_kind,
   input  wire logic                req_last,
   input  wire logic                mean_mode,
   input  wire logic [$clog2(MAX_DIM+1)-1:0] n_cols,
   input  wire logic                div_done,
   output logic                     busy,
   output ebp_pkg::ebp_cmd_type     cmd,
   output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] col
);

   localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int NW = $clog2(MAX_DIM + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ACC   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_EVAL  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_CLEAR = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic          last_ff, last_in;
   logic          at_last;

   assign at_last = col_ff == CW'(n_cols - NW'(1));

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.last_col = at_last;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == ebp_pkg::REQ_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.lookup_load = 1'b1;
                  last_in  = req_last;
                  col_in   = '0;
                  state_in = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            cmd.acc_issue = 1'b1;
            if (at_last) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            col_in   = '0;
            state_in = last_ff ? ST_RD : ST_IDLE;
         end
         ST_RD: begin
            cmd.acc_read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (mean_mode == ebp_pkg::POOL_MEAN) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.emit_sum = 1'b1;
               if (at_last) begin
                  state_in = ST_CLEAR;
               end else begin
                  col_in   = col_ff + CW'(1);
                  state_in = ST_RD;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               cmd.emit_div = 1'b1;
               if (at_last) begin
                  state_in = ST_CLEAR;
               end else begin
                  col_in   = col_ff + CW'(1);
                  state_in = ST_RD;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
      col_ff <= col_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign col  = col_ff;

endmodule

`default_nettype wire

[rtl/embedding_bag_pool.sv]
// a weight write is taken from idle; a lookup accumulates every column in use
// (emb_dim_used clamped to 1..MAX_DIM) with one table read and one accumulator add per column
// a closing lookup then gives one result per column, taken from the accumulator (sum) or
// from the bit-serial divider (mean); each result appears in the cycle after it is formed
// reset is synchronous: registers return to their reset values, accumulators
// read as zero, the weight table keeps its contents; results cannot be stalled
`default_nettype none

module embedding_bag_pool #(
   parameter int ROWS    = 1024,
   parameter int MAX_DIM = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire ebp_pkg::request_type req_data,
   output logic                      rsp_strobe,
   output ebp_pkg::result_type       rsp_data,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int NW = $clog2(MAX_DIM + 1);

   logic                 mode_ff;
   logic [4:0]           dim_ff;
   logic [NW-1:0]        n_cols;
   logic                 csr_wr;
   logic                 div_done;
   logic [CW-1:0]        col;
   ebp_pkg::ebp_cmd_type cmd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ebp_pkg::POOL_SUM;
         dim_ff  <= ebp_pkg::EMB_DIM_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == ebp_pkg::CSR_POOLING_MODE) begin
            mode_ff <= csr_pwdata[0];
         end else begin
            dim_ff <= csr_pwdata[4:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == ebp_pkg::CSR_POOLING_MODE) ?
                       {31'd0, mode_ff} : {27'd0, dim_ff};

   // columns in use, clamped to 1..MAX_DIM
   always_comb begin
      if (dim_ff == 5'd0) begin
         n_cols = NW'(1);
      end else if (32'(dim_ff) > MAX_DIM) begin
         n_cols = NW'(MAX_DIM);
      end else begin
         n_cols = NW'(dim_ff);
      end
   end

   ebp_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_data.req_type),
      .req_last  (req_data.last_in_bag),
      .mean_mode (mode_ff),
      .n_cols    (n_cols),
      .div_done  (div_done),
      .busy      (busy),
      .cmd       (cmd),
      .col       (col)
   );

   ebp_datapath #(
      .ROWS    (ROWS),
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .col        (col),
      .req        (req_data),
      .div_done   (div_done),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a bag close");

   a_busy_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && $past(req_data.req_type) == ebp_pkg::REQ_LOOKUP)
      else $error("busy rose without an accepted lookup request");

   a_last_ends_bag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_of_bag |=> !rsp_strobe)
      else $error("result after the bag's final column");
`endif

endmodule

`default_nettype wire
